// ===== sv/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
// Holds the transfer payload structs, the table entry layout and the field codes.
// Depends on nothing; every other file refers to it by scoped names.
package ffba_pkg;

  localparam int SIZE_BITS = 24;
  localparam int REG_BITS  = 32;
  localparam int SUM_BITS  = 34;

  // Item kinds.
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NO_MEMORY = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Configuration register indexes.
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]           kind;
    logic [SIZE_BITS-1:0] request_bytes;
    logic [REG_BITS-1:0]  payload_address;
  } request_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 reused;
    logic [REG_BITS-1:0]  result_address;
    logic [SIZE_BITS-1:0] block_bytes;
  } response_t;

  typedef struct packed {
    logic [REG_BITS-1:0]  offset;
    logic [SIZE_BITS-1:0] size;
    logic                 in_use;
  } entry_t;

endpackage

// ===== sv/ffba_round.sv =====
// Round-up unit: rounds a byte count up to a multiple of the word size.
// The quotient comes from a reciprocal multiply and one correction step.
// Depends on ffba_pkg for the size width.
module ffba_round #(
  parameter int WORD_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ffba_pkg::SIZE_BITS-1:0] request_bytes,
  output logic                          done,
  output logic [ffba_pkg::SIZE_BITS:0]   need
);

  localparam int ZB = ffba_pkg::SIZE_BITS;
  localparam int K  = ZB + 3;
  localparam int PW = ZB + K;
  localparam int RW = $clog2(2 * WORD_BYTES);
  localparam logic [K-1:0]  RECIP = K'((64'd1 << K) / 64'(WORD_BYTES));
  localparam logic [ZB-1:0] W = ZB'(WORD_BYTES);

  logic              mul_pending;
  logic              fix_pending;
  logic [ZB-1:0]     req_q;
  logic [PW-1:0]     prod;
  logic [ZB-1:0]     quot;
  logic [ZB-1:0]     rem_raw;
  logic [RW-1:0]     rem;

  // The reciprocal is rounded down, so the quotient estimate is exact or one
  // short, and a single conditional subtract brings the remainder into range.
  assign quot    = prod[PW-1:K];
  assign rem_raw = req_q - quot * W;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pending <= 1'b0;
      fix_pending <= 1'b0;
      done        <= 1'b0;
    end else begin
      mul_pending <= start;
      fix_pending <= mul_pending;
      done        <= fix_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_q <= request_bytes;
    end
    if (mul_pending) begin
      prod <= PW'(req_q) * PW'(RECIP);
    end
    if (fix_pending) begin
      rem <= (rem_raw >= W) ? RW'(rem_raw - W) : RW'(rem_raw);
    end
  end

  assign need = {1'b0, req_q} + ((rem == '0) ? '0 : ((ZB + 1)'(W) - (ZB + 1)'(rem)));

endmodule

// ===== sv/first_fit_block_allocator_core.sv =====
// First-fit block allocator. An allocate first rounds the size up in ffba_round, then walks the
// block table one entry per cycle through its single registered read port; a size that overflows
// the rounding fails without a walk. A free walks the same table; a heap reset or an unused kind
// goes straight to its result, and a match ends a walk early. One item is in flight at a time
// and in_ready is low meanwhile; a finished result waits in the output register, the next item
// is taken in the following cycle, and an item that finishes while the previous result is still
// unaccepted is held until that transfer completes. Depends on ffba_pkg and ffba_round.
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS   = 64,
  parameter int WORD_BYTES   = 8,
  parameter int HEADER_BYTES = 24,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffba_pkg::request_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ffba_pkg::response_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SB = ffba_pkg::SUM_BITS;
  localparam int ZB = ffba_pkg::SIZE_BITS;
  localparam int CMP_BITS = (ADDRESS_BITS < SB) ? ADDRESS_BITS : SB;
  localparam logic [SB-1:0] AMASK = (CMP_BITS == SB) ? {SB{1'b1}} :
                                    ((SB'(1) << CMP_BITS) - SB'(1));
  localparam logic [SB-1:0] HDR = SB'(HEADER_BYTES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ROUND  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [2:0] ACT_ZERO   = 3'd0;
  localparam logic [2:0] ACT_CLEAR  = 3'd1;
  localparam logic [2:0] ACT_FAIL   = 3'd2;
  localparam logic [2:0] ACT_REUSE  = 3'd3;
  localparam logic [2:0] ACT_FREED  = 3'd4;
  localparam logic [2:0] ACT_APPEND = 3'd5;
  localparam logic [2:0] ACT_MISS   = 3'd6;

  logic [1:0]              state;
  logic [2:0]              action;
  logic                    is_alloc;
  logic [31:0]             want;
  logic [ZB-1:0]           need;
  logic [CNT_W-1:0]        scan_idx;
  logic                    chk_valid;
  logic [IDX_W-1:0]        chk_idx;
  logic [IDX_W-1:0]        hit_idx;
  ffba_pkg::entry_t        hit_entry;
  logic [CNT_W-1:0]        count;
  logic [31:0]             brk;
  logic [31:0]             heap_base;
  logic [31:0]             heap_limit;

  ffba_pkg::entry_t        table_mem [MAX_BLOCKS];
  ffba_pkg::entry_t        rd_data;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  ffba_pkg::entry_t        wr_data;

  logic                    round_start;
  logic                    round_done;
  logic [ZB:0]             round_need;

  logic                    accept;
  logic                    slot_free;
  logic                    issue;
  logic                    hit;
  logic [SB-1:0]           scan_payload;
  logic [31:0]             fin_offset;
  logic [SB-1:0]           fin_payload;
  logic [SB-1:0]           total;
  logic                    append_fail;
  logic                    cfg_write;
  ffba_pkg::response_t     out_item_next;

  ffba_round #(
    .WORD_BYTES(WORD_BYTES)
  ) u_round (
    .clk          (clk),
    .rst          (rst),
    .start        (round_start),
    .request_bytes(in_item.request_bytes),
    .done         (round_done),
    .need         (round_need)
  );

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign round_start = accept && (in_item.kind == ffba_pkg::KIND_ALLOC);
  assign slot_free   = !out_valid || out_ready;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == ffba_pkg::REG_HEAP_LIMIT) ? heap_limit : heap_base;

  // Table scan: one read is issued per cycle, and the registered data is
  // checked in the following cycle.
  assign issue        = (scan_idx < count);
  assign rd_addr      = scan_idx[IDX_W-1:0];
  assign scan_payload = ({2'b0, heap_base} + {2'b0, rd_data.offset} + HDR) & AMASK;

  always_comb begin
    if (is_alloc) begin
      hit = chk_valid && !rd_data.in_use && (rd_data.size >= need);
    end else begin
      hit = chk_valid && (scan_payload == ({2'b0, want} & AMASK));
    end
  end

  // Completion arithmetic.
  assign fin_offset  = (action == ACT_APPEND) ? brk : hit_entry.offset;
  assign fin_payload = ({2'b0, heap_base} + {2'b0, fin_offset} + HDR) & AMASK;
  assign total       = {2'b0, brk} + SB'(need) + HDR;
  assign append_fail = (count >= CNT_W'(MAX_BLOCKS)) || (total > {2'b0, heap_limit});

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx;
    wr_data = hit_entry;
    if (state == S_FINISH && slot_free) begin
      unique case (action)
        ACT_REUSE: begin
          wr_en          = 1'b1;
          wr_data.in_use = 1'b1;
        end
        ACT_FREED: begin
          wr_en          = 1'b1;
          wr_data.in_use = 1'b0;
        end
        ACT_APPEND: begin
          wr_en          = !append_fail;
          wr_addr        = count[IDX_W-1:0];
          wr_data.offset = brk;
          wr_data.size   = need;
          wr_data.in_use = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_item_next = '0;
    unique case (action)
      ACT_REUSE: begin
        out_item_next.status         = ffba_pkg::STATUS_DONE;
        out_item_next.reused         = 1'b1;
        out_item_next.result_address = fin_payload[31:0];
        out_item_next.block_bytes    = hit_entry.size;
      end
      ACT_FREED: begin
        out_item_next.status         = ffba_pkg::STATUS_DONE;
        out_item_next.result_address = fin_payload[31:0];
        out_item_next.block_bytes    = hit_entry.size;
      end
      ACT_APPEND: begin
        if (append_fail) begin
          out_item_next.status = ffba_pkg::STATUS_NO_MEMORY;
        end else begin
          out_item_next.status         = ffba_pkg::STATUS_DONE;
          out_item_next.result_address = fin_payload[31:0];
          out_item_next.block_bytes    = need;
        end
      end
      ACT_FAIL: out_item_next.status = ffba_pkg::STATUS_NO_MEMORY;
      ACT_MISS: out_item_next.status = ffba_pkg::STATUS_NOT_FOUND;
      default:  out_item_next.status = ffba_pkg::STATUS_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= table_mem[rd_addr];
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chk_valid  <= 1'b0;
      count      <= '0;
      brk        <= '0;
      out_valid  <= 1'b0;
      heap_base  <= 32'h1000_0000;
      heap_limit <= 32'h0010_0000;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == ffba_pkg::REG_HEAP_BASE) begin
          heap_base <= pwdata;
        end else begin
          heap_limit <= pwdata;
        end
      end
      if (state == S_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          chk_valid <= 1'b0;
          if (accept) begin
            priority case (in_item.kind)
              ffba_pkg::KIND_ALLOC: state <= S_ROUND;
              ffba_pkg::KIND_FREE:  state <= S_SCAN;
              default:              state <= S_FINISH;
            endcase
          end
        end
        S_ROUND: begin
          if (round_done) begin
            state <= round_need[ZB] ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          chk_valid <= issue && !hit;
          if (hit || (!issue && !chk_valid)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
            if (action == ACT_CLEAR) begin
              count <= '0;
              brk   <= '0;
            end else if (action == ACT_APPEND && !append_fail) begin
              count <= count + CNT_W'(1);
              brk   <= total[31:0];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the item in flight and the result register.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        scan_idx <= '0;
        if (accept) begin
          is_alloc <= (in_item.kind == ffba_pkg::KIND_ALLOC);
          want     <= in_item.payload_address;
          action   <= (in_item.kind == ffba_pkg::KIND_CLEAR) ? ACT_CLEAR : ACT_ZERO;
        end
      end
      S_ROUND: begin
        if (round_done) begin
          need   <= round_need[ZB-1:0];
          action <= ACT_FAIL;
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        chk_idx <= scan_idx[IDX_W-1:0];
        if (hit) begin
          hit_idx   <= chk_idx;
          hit_entry <= rd_data;
          action    <= is_alloc ? ACT_REUSE : ACT_FREED;
        end else if (!issue && !chk_valid) begin
          action <= is_alloc ? ACT_APPEND : ACT_MISS;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_item <= out_item_next;
        end
      end
      default: scan_idx <= '0;
    endcase
  end

endmodule
